// File: design/satt_pkg.sv
// Shared types and constants for the scaled alarm timer table.
// No dependencies; every other design file refers to it by scoped names.
package satt_pkg;

    localparam int ALARM_SLOTS = 16;
    localparam int SLOT_IW     = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

    localparam int SLOT_W  = 4;
    localparam int DUR_W   = 31;
    localparam int DELTA_W = 24;
    localparam int SCALE_W = 16;
    localparam int FRAC_W  = 8;
    localparam int PROD_W  = DELTA_W + SCALE_W;
    localparam int SD_W    = PROD_W - FRAC_W;
    localparam int REM_W   = 33;
    localparam int OVER_W  = 24;
    localparam int TIME_W  = 64;

    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam logic [1:0] REG_MAX_DELTA  = 2'd0;
    localparam logic [1:0] REG_TIME_SCALE = 2'd1;
    localparam logic [1:0] REG_PAUSED     = 2'd2;

    localparam logic [DELTA_W-1:0] MAX_DELTA_RST  = 24'd500000;
    localparam logic [SCALE_W-1:0] TIME_SCALE_RST = 16'd256;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    typedef struct packed {
        logic [DELTA_W-1:0] max_delta;
        logic [SCALE_W-1:0] time_scale;
        logic               paused;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [DELTA_W-1:0] delta;
    } scale_req_t;

    typedef struct packed {
        logic            done;
        logic [SD_W-1:0] value;
    } scale_res_t;

endpackage

// File: design/satt_in_if.sv
// Input channel: tick / arm command transactions.
// Depends on satt_pkg for field widths.
interface satt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [satt_pkg::SLOT_W-1:0]  slot;
    logic [satt_pkg::DUR_W-1:0]   duration;
    logic [satt_pkg::DELTA_W-1:0] delta;

    modport source (output valid, command, slot, duration, delta, input ready);
    modport sink   (input valid, command, slot, duration, delta, output ready);
endinterface

// File: design/satt_out_if.sv
// Output channel: one transaction per fired alarm.
// Depends on satt_pkg for field widths.
interface satt_out_if;
    logic                        valid;
    logic                        ready;
    logic [satt_pkg::SLOT_W-1:0] fired_slot;
    logic [satt_pkg::OVER_W-1:0] overshoot;
    logic [satt_pkg::TIME_W-1:0] current_time;
    logic                        last_of_tick;

    modport source (output valid, fired_slot, overshoot, current_time, last_of_tick,
                    input ready);
    modport sink   (input valid, fired_slot, overshoot, current_time, last_of_tick,
                    output ready);
endinterface

// File: design/scaled_alarm_timer_table_unit.sv
// Top level of the scaled alarm timer table.
// Depends on satt_pkg, satt_in_if, satt_out_if, satt_cfg, satt_scale, satt_table.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  in_ch    | sink      | valid/ready            | command, slot, duration, delta
//  out_ch   | source    | valid/ready            | fired_slot, overshoot, current_time, last
//  apb      | slave     | psel/penable, pready=1 | paddr[3:0], pwdata/prdata 32 bit
//
// An arm transaction is written into the table while idle. A tick passes through the
//   registered clamp-and-multiply and the first memory read, then through the
//   read-modify-write of the remaining-time RAM slot by slot, and ends in a flush state
//   for the final result of the tick.
// Reset clears the armed flags, time base and registers at once; no clearing pass is run.
// Output backpressure freezes the slot scan while the output register is full, and holds
//   the flush cycle until the final result moves into it; the next transaction is taken
//   right after that, even while the result still waits to be taken.
module scaled_alarm_timer_table_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    satt_in_if.sink                     in_ch,
    satt_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [satt_pkg::CFG_AW-1:0] paddr,
    input  logic [satt_pkg::CFG_DW-1:0] pwdata,
    output logic [satt_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);

    satt_pkg::cfg_t       cfg;
    satt_pkg::scale_req_t scale_req;
    satt_pkg::scale_res_t scale_res;

    // register file; the user must write it only while the table is idle (not enforced here)
    satt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // clamp, Q8.8 multiply, pause gating
    satt_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (scale_req),
        .res   (scale_res)
    );

    // alarm memory, armed flags, scan and result staging
    satt_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .scale_req (scale_req),
        .scale_res (scale_res)
    );

endmodule

// File: design/satt_cfg.sv
// APB-style configuration registers: max_delta, time_scale, paused.
// Depends on satt_pkg.
module satt_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [satt_pkg::CFG_AW-1:0] paddr,
    input  logic [satt_pkg::CFG_DW-1:0] pwdata,
    output logic [satt_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output satt_pkg::cfg_t              cfg
);

    logic [satt_pkg::DELTA_W-1:0] max_delta_reg;
    logic [satt_pkg::SCALE_W-1:0] time_scale_reg;
    logic                         paused_reg;
    logic [1:0]                   reg_idx;
    logic                         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[satt_pkg::CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_delta_reg  <= satt_pkg::MAX_DELTA_RST;
            time_scale_reg <= satt_pkg::TIME_SCALE_RST;
            paused_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                satt_pkg::REG_MAX_DELTA:  max_delta_reg  <= pwdata[satt_pkg::DELTA_W-1:0];
                satt_pkg::REG_TIME_SCALE: time_scale_reg <= pwdata[satt_pkg::SCALE_W-1:0];
                satt_pkg::REG_PAUSED:     paused_reg     <= pwdata[0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            satt_pkg::REG_MAX_DELTA:  prdata = satt_pkg::CFG_DW'(max_delta_reg);
            satt_pkg::REG_TIME_SCALE: prdata = satt_pkg::CFG_DW'(time_scale_reg);
            satt_pkg::REG_PAUSED:     prdata = satt_pkg::CFG_DW'(paused_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.max_delta  = max_delta_reg;
    assign cfg.time_scale = time_scale_reg;
    assign cfg.paused     = paused_reg;

endmodule

// File: design/satt_scale.sv
// Delta clamp and Q8.8 scaling: one registered 24x16 multiply.
// Depends on satt_pkg.
module satt_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  satt_pkg::cfg_t       cfg,
    input  satt_pkg::scale_req_t req,
    output satt_pkg::scale_res_t res
);

    logic [satt_pkg::DELTA_W-1:0] clamped;
    logic [satt_pkg::PROD_W-1:0]  prod_reg;
    logic                         done_reg;

    assign clamped = (req.delta > cfg.max_delta) ? cfg.max_delta : req.delta;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            prod_reg <= '0;
        end
        else
        begin
            done_reg <= req.start;
            if (req.start)
                prod_reg <= satt_pkg::PROD_W'(clamped) * satt_pkg::PROD_W'(cfg.time_scale);
        end
    end

    // truncating shift drops the Q8.8 fraction
    assign res.done  = done_reg;
    assign res.value = cfg.paused ? '0 : prod_reg[satt_pkg::PROD_W-1:satt_pkg::FRAC_W];

endmodule

// File: design/satt_table.sv
// Alarm table: remaining-time memory, armed flags, slot scan and result staging.
// Depends on satt_pkg, satt_in_if, satt_out_if.
module satt_table (
    input  logic                 clk,
    input  logic                 rst_n,
    satt_in_if.sink              in_ch,
    satt_out_if.source           out_ch,
    output satt_pkg::scale_req_t scale_req,
    input  satt_pkg::scale_res_t scale_res
);

    localparam int IW = satt_pkg::SLOT_IW;
    localparam logic [IW-1:0] SLOT_LAST = IW'(satt_pkg::ALARM_SLOTS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_SCAN, ST_FLUSH} state_t;

    state_t                            state_reg;
    logic [satt_pkg::ALARM_SLOTS-1:0]  armed_reg;
    logic [satt_pkg::TIME_W-1:0]       acc_reg;
    logic [satt_pkg::SD_W-1:0]         sd_reg;
    logic [IW-1:0]                     proc_slot_reg;
    logic [satt_pkg::REM_W-1:0]        mem_rd_reg;
    logic                              pend_valid_reg;
    logic [satt_pkg::SLOT_W-1:0]       pend_slot_reg;
    logic [satt_pkg::OVER_W-1:0]       pend_over_reg;
    logic                              out_valid_reg;
    logic [satt_pkg::SLOT_W-1:0]       out_slot_reg;
    logic [satt_pkg::OVER_W-1:0]       out_over_reg;
    logic [satt_pkg::TIME_W-1:0]       out_time_reg;
    logic                              out_last_reg;

    logic [satt_pkg::REM_W-1:0] rem_mem [satt_pkg::ALARM_SLOTS];

    logic                       in_acc;
    logic                       tick_acc;
    logic                       arm_ok;
    logic [IW-1:0]              arm_idx;
    logic                       stall;
    logic                       scan_go;
    logic                       proc_armed;
    logic                       proc_last;
    logic                       fire;
    logic [satt_pkg::REM_W-1:0] wb_value;
    logic [satt_pkg::REM_W-1:0] neg_value;
    logic [satt_pkg::OVER_W-1:0] over_sat;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    logic [satt_pkg::REM_W-1:0] wr_data;
    logic                       scan_load;
    logic                       flush_load;
    logic                       out_load;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign tick_acc    = in_acc && (in_ch.command == satt_pkg::CMD_TICK);
    assign arm_idx     = IW'(in_ch.slot);
    assign arm_ok      = in_acc && (in_ch.command == satt_pkg::CMD_ARM)
                         && (32'(in_ch.slot) < 32'(satt_pkg::ALARM_SLOTS))
                         && !armed_reg[arm_idx];

    assign scale_req.start = tick_acc;
    assign scale_req.delta = in_ch.delta;

    // scan freezes while the output register holds an untaken result
    assign stall      = out_valid_reg && !out_ch.ready;
    assign scan_go    = (state_reg == ST_SCAN) && !stall;
    assign proc_armed = armed_reg[proc_slot_reg];
    assign proc_last  = (proc_slot_reg == SLOT_LAST);

    // remaining time before the tick is in [0, 2^31), delta below 2^32: fits 33 bits signed
    assign wb_value  = mem_rd_reg - {1'b0, sd_reg};
    assign fire      = scan_go && proc_armed
                       && (wb_value[satt_pkg::REM_W-1] || (wb_value == '0));
    assign neg_value = '0 - wb_value;
    assign over_sat  = (|neg_value[satt_pkg::REM_W-1:satt_pkg::OVER_W]) ? '1
                       : neg_value[satt_pkg::OVER_W-1:0];

    // read slot p+1 while slot p is written back: addresses never collide,
    // and arms land only while idle
    assign rd_en   = ((state_reg == ST_SCALE) && scale_res.done) || (scan_go && !proc_last);
    assign rd_addr = (state_reg == ST_SCALE) ? '0 : proc_slot_reg + 1'b1;
    assign wr_en   = arm_ok || (scan_go && proc_armed);
    assign wr_addr = (state_reg == ST_IDLE) ? arm_idx : proc_slot_reg;
    assign wr_data = (state_reg == ST_IDLE) ? satt_pkg::REM_W'(in_ch.duration) : wb_value;

    // a held result goes out once the next one is found, or at the end with last set
    assign scan_load  = fire && pend_valid_reg;
    assign flush_load = (state_reg == ST_FLUSH) && pend_valid_reg && !stall;
    assign out_load   = scan_load || flush_load;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rem_mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_rd_reg <= rem_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            armed_reg      <= '0;
            acc_reg        <= '0;
            sd_reg         <= '0;
            proc_slot_reg  <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
            pend_over_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_over_reg   <= '0;
            out_time_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_slot_reg  <= pend_slot_reg;
                out_over_reg  <= pend_over_reg;
                out_time_reg  <= acc_reg;
                out_last_reg  <= flush_load;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (arm_ok)
                        armed_reg[arm_idx] <= 1'b1;
                    if (tick_acc)
                        state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    if (scale_res.done)
                    begin
                        sd_reg        <= scale_res.value;
                        acc_reg       <= acc_reg + satt_pkg::TIME_W'(scale_res.value);
                        proc_slot_reg <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_go)
                    begin
                        if (fire)
                        begin
                            armed_reg[proc_slot_reg] <= 1'b0;
                            pend_valid_reg <= 1'b1;
                            pend_slot_reg  <= satt_pkg::SLOT_W'(proc_slot_reg);
                            pend_over_reg  <= over_sat;
                        end
                        if (proc_last)
                            state_reg <= ST_FLUSH;
                        else
                            proc_slot_reg <= proc_slot_reg + 1'b1;
                    end
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg)
                        state_reg <= ST_IDLE;
                    else if (!stall)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.fired_slot   = out_slot_reg;
    assign out_ch.overshoot    = out_over_reg;
    assign out_ch.current_time = out_time_reg;
    assign out_ch.last_of_tick = out_last_reg;

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held result left over after tick");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ch.ready))
        else $error("output register overwritten before taken");

    a_done_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
        scale_res.done |-> (state_reg == ST_SCALE))
        else $error("scaled delta arrived outside scale wait");

    a_acc_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !scale_res.done |=> $stable(acc_reg))
        else $error("accumulated time moved without a tick");

    a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> !armed_reg[$past(proc_slot_reg)])
        else $error("fired slot still armed");

endmodule
